>>> design/twq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twq_pkg
// Shared types and constants of the timed wait queue: the request and
// response beat layouts, operation codes, sequencer states and step results.
// ----------------------------------------------------------------------------
package twq_pkg;

	// Queue geometry.
	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_BITS = 16;

	// Operation codes carried in the op field.
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_POP    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_FIND   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;
	localparam logic [2:0] OP_TICK   = 3'd5;

	// Request beat.
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] task_id;
		logic [15:0] wait_ticks;
		logic [3:0]  position;
		logic [15:0] count_in;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [15:0] out_id;
		logic [15:0] out_ticks;
		logic        found;
		logic        is_full;
		logic        woken;
		logic [15:0] count_out;
		logic [4:0]  occupancy;
		logic        last;
	} rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SWEEP,
		ST_FIND,
		ST_READ,
		ST_EMIT
	} state_t;

	// Result of evaluating one queue entry.
	typedef struct packed {
		logic        match;
		logic        expire;
		logic [15:0] ticks_dec;
	} step_t;

endpackage

>>> design/timed_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_wait_queue
// Bounded ordered queue of blocked task ids with per-entry timeouts.
// ----------------------------------------------------------------------------
// A request beat on req carries one operation: append, pop head, remove by
// id, find by id, read by position or tick. req_ready is high only while the
// sequencer is idle; one request is worked on at a time.
// Responses leave on rsp through an output register. Every operation gives
// one beat with last set, except a tick, which gives one beat per released
// task in queue order and then a summary beat with last set.
// Append and unused codes go straight to the response; read first fetches
// the entry. Find walks the entries one per cycle. Pop and remove compact
// the queue in one pass; a tick makes a counting pass and a compacting
// pass. All walks share the single entry evaluation unit and the single
// registered read port of the entry store. A stalled receiver holds the
// walk whenever a beat must leave.
// Reset empties the queue; entry contents are not cleared.
// ----------------------------------------------------------------------------
module timed_wait_queue import twq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Entry store.
	logic [ID_BITS-1:0] ids_q   [DEPTH];
	logic [15:0]        ticks_q [DEPTH];

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   wr_q, wr_d;
	logic [CNT_W-1:0]   nwake_q, nwake_d;
	logic [CNT_W-1:0]   final_q, final_d;
	logic [2:0]         op_q, op_d;
	logic [ID_BITS-1:0] key_q, key_d;
	logic [15:0]        base_q, base_d;
	logic               hit_q, hit_d;
	rsp_t               res_q, res_d;
	rsp_t               out_q, out_d;
	logic               out_valid_q, out_valid_d;

	logic [IDX_W-1:0]   rd_addr;
	logic [ID_BITS-1:0] rd_id_q;
	logic [15:0]        rd_ticks_q;
	logic               we;
	logic [IDX_W-1:0]   wr_addr;
	logic [ID_BITS-1:0] wr_id;
	logic [15:0]        wr_ticks;
	step_t              step;
	logic               out_free;
	logic               drop;
	logic [16:0]        sum;

	// The read port fetches the entry that the walk looks at next cycle.
	assign rd_addr = idx_d[IDX_W-1:0];

	twq_step u_step (
		.ent_id    (rd_id_q),
		.ent_ticks (rd_ticks_q),
		.key       (key_q),
		.res       (step)
	);

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign sum       = {1'b0, base_q} + 17'(nwake_q);

	// Which entry the compacting pass leaves out.
	always_comb begin
		if (op_q == OP_TICK) begin
			drop = step.expire;
		end else if (op_q == OP_POP) begin
			drop = !hit_q && (idx_q == '0);
		end else begin
			drop = !hit_q && step.match;
		end
	end

	// Sequencer: next state, store writes and response beats.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		wr_d        = wr_q;
		nwake_d     = nwake_q;
		final_d     = final_q;
		op_d        = op_q;
		key_d       = key_q;
		base_d      = base_q;
		hit_d       = hit_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = rsp_ready ? 1'b0 : out_valid_q;
		we          = 1'b0;
		wr_addr     = wr_q[IDX_W-1:0];
		wr_id       = rd_id_q;
		wr_ticks    = rd_ticks_q;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					op_d    = req.op;
					key_d   = req.task_id[ID_BITS-1:0];
					base_d  = req.count_in;
					hit_d   = 1'b0;
					idx_d   = '0;
					wr_d    = '0;
					nwake_d = '0;
					res_d   = '0;
					res_d.occupancy = 5'(count_q);
					res_d.last      = 1'b1;
					state_d = ST_EMIT;
					case (req.op)
						OP_APPEND: begin
							res_d.out_id    = req.task_id;
							res_d.out_ticks = req.wait_ticks;
							if (count_q >= CNT_W'(DEPTH)) begin
								res_d.is_full = 1'b1;
							end else begin
								we       = 1'b1;
								wr_addr  = count_q[IDX_W-1:0];
								wr_id    = req.task_id[ID_BITS-1:0];
								wr_ticks = req.wait_ticks;
								count_d  = count_q + 1'b1;
								res_d.found     = 1'b1;
								res_d.occupancy = 5'(count_q + 1'b1);
							end
						end
						OP_POP, OP_REMOVE: begin
							state_d = ST_SWEEP;
						end
						OP_FIND: begin
							state_d = ST_FIND;
						end
						OP_READ: begin
							idx_d   = CNT_W'(req.position);
							state_d = ST_READ;
						end
						OP_TICK: begin
							state_d = ST_COUNT;
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end

			// First tick pass: count the entries that expire on this tick.
			ST_COUNT: begin
				if (idx_q == count_q) begin
					final_d = count_q - nwake_q;
					idx_d   = '0;
					state_d = ST_SWEEP;
				end else begin
					if (step.expire) begin
						nwake_d = nwake_q + 1'b1;
					end
					idx_d = idx_q + 1'b1;
				end
			end

			// Compacting pass: kept entries move down, the dropped ones leave.
			ST_SWEEP: begin
				if (idx_q == count_q) begin
					count_d = wr_q;
					res_d.occupancy = 5'(wr_q);
					res_d.last      = 1'b1;
					if (op_q == OP_TICK) begin
						res_d.out_id    = '0;
						res_d.out_ticks = '0;
						res_d.found     = 1'b0;
						res_d.count_out = sum[16] ? 16'hFFFF : sum[15:0];
					end else begin
						res_d.found = hit_q;
					end
					state_d = ST_EMIT;
				end else if (drop) begin
					if (op_q == OP_TICK) begin
						// A released task leaves as a beat at once.
						if (out_free) begin
							out_d           = '0;
							out_d.out_id    = 16'(rd_id_q);
							out_d.found     = 1'b1;
							out_d.woken     = 1'b1;
							out_d.occupancy = 5'(final_q);
							out_valid_d     = 1'b1;
							idx_d           = idx_q + 1'b1;
						end
					end else begin
						hit_d           = 1'b1;
						res_d.out_id    = 16'(rd_id_q);
						res_d.out_ticks = rd_ticks_q;
						idx_d           = idx_q + 1'b1;
					end
				end else begin
					we   = 1'b1;
					if (op_q == OP_TICK) begin
						wr_ticks = step.ticks_dec;
					end
					wr_d  = wr_q + 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end

			// Search from the head for the first matching id.
			ST_FIND: begin
				if (idx_q == count_q) begin
					state_d = ST_EMIT;
				end else if (step.match) begin
					res_d.out_id    = 16'(rd_id_q);
					res_d.out_ticks = rd_ticks_q;
					res_d.found     = 1'b1;
					state_d         = ST_EMIT;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end

			// The entry at the requested position has been fetched.
			ST_READ: begin
				if (idx_q < count_q) begin
					res_d.out_id    = 16'(rd_id_q);
					res_d.out_ticks = rd_ticks_q;
					res_d.found     = 1'b1;
				end
				state_d = ST_EMIT;
			end

			// Hand the prepared response to the output register.
			ST_EMIT: begin
				if (out_free) begin
					out_d       = res_q;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working registers and response payload.
	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		wr_q    <= wr_d;
		nwake_q <= nwake_d;
		final_q <= final_d;
		op_q    <= op_d;
		key_q   <= key_d;
		base_q  <= base_d;
		hit_q   <= hit_d;
		res_q   <= res_d;
		out_q   <= out_d;
	end

	// Entry store: one write port and one registered read port. The walk
	// never reads an entry in the cycle that it is rewritten.
	always_ff @(posedge clk) begin
		if (we) begin
			ids_q[wr_addr]   <= wr_id;
			ticks_q[wr_addr] <= wr_ticks;
		end
		rd_id_q    <= ids_q[rd_addr];
		rd_ticks_q <= ticks_q[rd_addr];
	end

endmodule

>>> design/twq_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twq_step
// Entry evaluation unit shared by every walk over the queue: compares the
// entry id with the key and works out the decremented wait and expiry.
// ----------------------------------------------------------------------------
module twq_step import twq_pkg::*; (
	input  logic [ID_BITS-1:0] ent_id,
	input  logic [15:0]        ent_ticks,
	input  logic [ID_BITS-1:0] key,
	output step_t              res
);

	// An entry with no timeout keeps a zero count; any other count drops by one.
	always_comb begin
		res.match     = (ent_id == key);
		res.expire    = (ent_ticks == 16'd1);
		res.ticks_dec = (ent_ticks == 16'd0) ? 16'd0 : ent_ticks - 16'd1;
	end

endmodule

>>> tb/timed_wait_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_wait_queue_tb
// Self-checking bench for the timed wait queue: a shadow wait list predicts
// every response beat, and a clocked monitor compares the beats as they leave.
// ----------------------------------------------------------------------------
// A directed opening fills the queue to its limit and touches the empty,
// full, duplicate-id, out-of-range and saturating-count cases. Random phases
// follow, mostly bursts of appends with short timeouts and then ticks, mixed
// with single operations on a small pool of ids. The phases vary the request
// gaps and the response stalls. In one phase the receiver holds off for a long
// stretch so that the block backs up. The sender drains between phases.
// ----------------------------------------------------------------------------
module timed_wait_queue_tb import twq_pkg::*; ();

	// Codes the block leaves unused.
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 2 * DEPTH + 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req       = '0;
	logic rsp_valid;
	logic req_ready;
	rsp_t rsp;

	// Requests waiting to be offered, and response beats still owed.
	req_t req_backlog[$];
	rsp_t expected_rsps[$];

	// Shadow copy of the wait list.
	logic [15:0] shadow_ids[DEPTH];
	logic [15:0] shadow_ticks[DEPTH];
	int shadow_count = 0;

	// Ids that random requests mostly draw from, so that finds and removes hit.
	logic [15:0] id_pool[8];

	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;
	int hold_requests     = 0;
	int hold_served       = 0;
	int hold_left         = 0;

	int error_count       = 0;
	int requests_accepted = 0;
	int beats_checked     = 0;
	int tasks_released    = 0;
	int full_refusals     = 0;
	int peak_occupancy    = 0;

	timed_wait_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// Position of the first entry holding the id, or -1 when there is none.
	function automatic int locate_id(input logic [15:0] id);
		int i;
		for (i = 0; i < shadow_count; i++) begin
			if (shadow_ids[i] == id)
				return i;
		end
		return -1;
	endfunction

	// Closes the gap left by removing one entry.
	task automatic drop_entry(input int slot);
		int i;
		for (i = slot; i + 1 < shadow_count; i++) begin
			shadow_ids[i]   = shadow_ids[i + 1];
			shadow_ticks[i] = shadow_ticks[i + 1];
		end
		shadow_count--;
	endtask

	// Applies one accepted request to the shadow list and queues the beats
	// that it must produce.
	task automatic forecast_responses(input req_t r);
		rsp_t beat;
		int hit;
		int i;
		logic [15:0] released[$];
		logic [16:0] total;
		beat = '0;
		case (r.op)
			OP_APPEND: begin
				beat.out_id    = r.task_id;
				beat.out_ticks = r.wait_ticks;
				if (shadow_count >= DEPTH) begin
					beat.is_full = 1'b1;
					full_refusals++;
				end else begin
					shadow_ids[shadow_count]   = r.task_id;
					shadow_ticks[shadow_count] = r.wait_ticks;
					shadow_count++;
					beat.found = 1'b1;
				end
			end
			OP_POP, OP_REMOVE: begin
				if (r.op == OP_POP)
					hit = (shadow_count > 0) ? 0 : -1;
				else
					hit = locate_id(r.task_id);
				if (hit >= 0) begin
					beat.out_id    = shadow_ids[hit];
					beat.out_ticks = shadow_ticks[hit];
					beat.found     = 1'b1;
					drop_entry(hit);
				end
			end
			OP_FIND: begin
				hit = locate_id(r.task_id);
				if (hit >= 0) begin
					beat.out_id    = shadow_ids[hit];
					beat.out_ticks = shadow_ticks[hit];
					beat.found     = 1'b1;
				end
			end
			OP_READ: begin
				if (r.position < shadow_count) begin
					beat.out_id    = shadow_ids[r.position];
					beat.out_ticks = shadow_ticks[r.position];
					beat.found     = 1'b1;
				end
			end
			OP_TICK: begin
				// Entries at one tick expire now; zero means no timeout.
				i = 0;
				while (i < shadow_count) begin
					if (shadow_ticks[i] == 16'd1) begin
						released.push_back(shadow_ids[i]);
						drop_entry(i);
					end else begin
						if (shadow_ticks[i] != 16'd0)
							shadow_ticks[i] = shadow_ticks[i] - 16'd1;
						i++;
					end
				end
				foreach (released[k]) begin
					beat           = '0;
					beat.out_id    = released[k];
					beat.found     = 1'b1;
					beat.woken     = 1'b1;
					beat.occupancy = shadow_count[4:0];
					expected_rsps.push_back(beat);
				end
				tasks_released += released.size();
				total = {1'b0, r.count_in} + 17'(released.size());
				beat           = '0;
				beat.count_out = total[16] ? 16'hFFFF : total[15:0];
			end
			default: begin
			end
		endcase
		beat.occupancy = shadow_count[4:0];
		beat.last      = 1'b1;
		expected_rsps.push_back(beat);
		if (shadow_count > peak_occupancy)
			peak_occupancy = shadow_count;
	endtask

	task automatic compare_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
		end
	endtask

	task automatic check_beat(input rsp_t got);
		rsp_t want;
		beats_checked++;
		if (expected_rsps.size() == 0) begin
			error_count++;
			$display("%0t: beat with nothing expected, expected none, got %h",
				$time, got);
		end else begin
			want = expected_rsps.pop_front();
			compare_field("out_id", want.out_id, got.out_id);
			compare_field("out_ticks", want.out_ticks, got.out_ticks);
			compare_field("found", 16'(want.found), 16'(got.found));
			compare_field("is_full", 16'(want.is_full), 16'(got.is_full));
			compare_field("woken", 16'(want.woken), 16'(got.woken));
			compare_field("count_out", want.count_out, got.count_out);
			compare_field("occupancy", 16'(want.occupancy), 16'(got.occupancy));
			compare_field("last", 16'(want.last), 16'(got.last));
		end
	endtask

	function automatic req_t make_req(input logic [2:0] op, input logic [15:0] id,
			input logic [15:0] ticks, input logic [3:0] pos, input logic [15:0] base);
		req_t item;
		item.op         = op;
		item.task_id    = id;
		item.wait_ticks = ticks;
		item.position   = pos;
		item.count_in   = base;
		return item;
	endfunction

	// One request of any kind, with every field filled at random.
	function automatic req_t random_request();
		req_t item;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			item.op = OP_APPEND;
		else if (pick < 40)
			item.op = OP_POP;
		else if (pick < 52)
			item.op = OP_REMOVE;
		else if (pick < 64)
			item.op = OP_FIND;
		else if (pick < 76)
			item.op = OP_READ;
		else if (pick < 96)
			item.op = OP_TICK;
		else if (pick < 98)
			item.op = OP_SPARE_A;
		else
			item.op = OP_SPARE_B;
		item.task_id = ($urandom_range(0, 99) < 65) ? id_pool[$urandom_range(0, 7)]
			: 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50)
			item.wait_ticks = 16'($urandom_range(1, 6));
		else if (pick < 65)
			item.wait_ticks = 16'd0;
		else if (pick < 80)
			item.wait_ticks = 16'($urandom);
		else if (pick < 90)
			item.wait_ticks = 16'hFFFF;
		else
			item.wait_ticks = 16'd1;
		item.position = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 40)
			item.count_in = 16'($urandom);
		else if (pick < 70)
			item.count_in = 16'($urandom_range(16'hFFF0, 16'hFFFF));
		else
			item.count_in = 16'($urandom_range(0, 20));
		return item;
	endfunction

	// Mostly bursts of appends with short timeouts followed by ticks, so that
	// the list fills and several tasks expire together; the rest are singles.
	task automatic queue_random_items(input int n);
		int made;
		int burst;
		req_t item;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 99) < 15) begin
				burst = $urandom_range(4, 16);
				repeat (burst) begin
					item            = random_request();
					item.op         = OP_APPEND;
					item.task_id    = id_pool[$urandom_range(0, 7)];
					item.wait_ticks = 16'($urandom_range(1, 4));
					req_backlog.push_back(item);
				end
				made += burst;
				burst = $urandom_range(1, 5);
				repeat (burst) begin
					item    = random_request();
					item.op = OP_TICK;
					req_backlog.push_back(item);
				end
				made += burst;
			end else begin
				req_backlog.push_back(random_request());
				made++;
			end
		end
	endtask

	// Waits until every request is taken and every owed beat has arrived.
	task automatic drain_all();
		while (req_backlog.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		@(negedge clk);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// Request driver: a beat is held until taken, then the next is offered
	// unless the sender chooses a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				forecast_responses(req);
				requests_accepted++;
			end
			if (!req_valid || req_ready) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: checks each beat taken and decides the next ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_beat(rsp);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// Run limit.
	initial begin
		#8_000_000;
		$display("timed_wait_queue_tb: errors");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		foreach (id_pool[i])
			id_pool[i] = 16'($urandom);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening: empty cases, fill to the limit, refusal, duplicate
		// removal, a saturating tick and an unused code.
		req_backlog.push_back(make_req(OP_TICK, 16'h0000, 16'h0000, 4'd0, 16'hFFFF));
		req_backlog.push_back(make_req(OP_POP, 16'hFFFF, 16'hFFFF, 4'hF, 16'h0000));
		req_backlog.push_back(make_req(OP_FIND, 16'hA5A5, 16'h0000, 4'd0, 16'h0000));
		for (int i = 0; i < DEPTH; i++) begin
			req_backlog.push_back(make_req(OP_APPEND,
				(i % 5 == 0) ? 16'hA5A5 : (i == 2) ? 16'h0000 : (i == 3) ? 16'hFFFF
					: 16'(i * 16'h1001),
				(i == DEPTH - 1) ? 16'hFFFF : (i % 4 == 0) ? 16'd0 : (i % 4 == 1) ? 16'd1
					: 16'(i / 4 + 2),
				4'(i), 16'(i)));
		end
		req_backlog.push_back(make_req(OP_APPEND, 16'h5A5A, 16'h0007, 4'd0, 16'h0000));
		req_backlog.push_back(make_req(OP_READ, 16'h0000, 16'h0000, 4'hF, 16'h0000));
		req_backlog.push_back(make_req(OP_REMOVE, 16'hA5A5, 16'h0000, 4'd0, 16'h0000));
		req_backlog.push_back(make_req(OP_TICK, 16'h0000, 16'h0000, 4'd0, 16'hFFFF));
		req_backlog.push_back(make_req(OP_READ, 16'h0000, 16'h0000, 4'hF, 16'h0000));
		req_backlog.push_back(make_req(OP_SPARE_A, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF));
		drain_all();

		// No idling, with one long receiver hold at the start.
		set_idling(0, 0);
		hold_requests++;
		queue_random_items(80);
		drain_all();

		// Sparse requests.
		set_idling(88, 0);
		queue_random_items(80);
		drain_all();

		// Heavily stalled receiver.
		set_idling(0, 88);
		queue_random_items(80);
		drain_all();

		// Both sides idling now and then.
		set_idling(24, 24);
		queue_random_items(90);
		drain_all();

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Run covered %0d requests and %0d response beats.",
			requests_accepted, beats_checked);
		$display("Tasks released by ticks: %0d, appends refused: %0d, peak occupancy: %0d.",
			tasks_released, full_refusals, peak_occupancy);
		if (error_count == 0)
			$display("timed_wait_queue_tb: clean");
		else
			$display("timed_wait_queue_tb: errors");
		$finish;
	end

endmodule
